[sv/fat_pkg.sv]
// ---------------------------------------------------------------------------
// fat_pkg: shared types and constants
// constants and inter-stage types of the truncating single-precision adder
// ---------------------------------------------------------------------------
`default_nettype none
package fat_pkg;
   localparam logic [22:0] FRAC_MASK  = 23'h7fffff;
   localparam logic [23:0] HIDDEN_ONE = 24'h800000;

   // stage 1 -> stage 2
   typedef struct packed {
      logic        sign;
      logic        pass;      // one operand had zero exponent
      logic [7:0]  exp_big;
      logic [23:0] man_big;
      logic [23:0] man_small;
      logic [7:0]  shift;
      logic        sub;
   } align_type;

   // stage 2 -> stage 3
   typedef struct packed {
      logic        sign;
      logic        pass;
      logic [7:0]  exp_big;
      logic [24:0] man_sum;
      logic [23:0] pass_man;
   } sum_type;
endpackage
`default_nettype wire

[sv/fat_align.sv]
// ---------------------------------------------------------------------------
// fat_align: unpack, sign decision and operand swap
// compares magnitudes and orders the operands for alignment
// ---------------------------------------------------------------------------
`default_nettype none
module fat_align (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        valid_in,
   input  wire logic [31:0] a_in,
   input  wire logic [31:0] b_in,
   output logic             valid_out,
   output fat_pkg::align_type data_out
);
   logic               valid_ff;
   fat_pkg::align_type data_ff, data_in;
   logic sa, sb, a_gt, b_gt;
   logic [7:0] ea, eb;
   logic [23:0] ma, mb;

   always_comb begin
      sa = a_in[31];
      sb = b_in[31];
      ea = a_in[30:23];
      eb = b_in[30:23];
      ma = {1'b0, a_in[22:0] & fat_pkg::FRAC_MASK} | fat_pkg::HIDDEN_ONE;
      mb = {1'b0, b_in[22:0] & fat_pkg::FRAC_MASK} | fat_pkg::HIDDEN_ONE;
      a_gt = (ea > eb) || ((ea == eb) && (ma > mb));
      b_gt = (ea < eb) || ((ea == eb) && (ma < mb));
      data_in.sign = (sa && sb) || (sa && a_gt) || (sb && b_gt);
      data_in.sub  = sa ^ sb;
      data_in.pass = (ea == 8'd0) || (eb == 8'd0);
      if (ea == 8'd0) begin
         // zero-exponent a passes b through
         data_in.exp_big   = eb;
         data_in.man_big   = mb;
         data_in.man_small = '0;
         data_in.shift     = '0;
      end else if (eb == 8'd0) begin
         data_in.exp_big   = ea;
         data_in.man_big   = ma;
         data_in.man_small = '0;
         data_in.shift     = '0;
      end else if (ea < eb) begin
         data_in.exp_big   = eb;
         data_in.man_big   = mb;
         data_in.man_small = ma;
         data_in.shift     = eb - ea;
      end else begin
         data_in.exp_big   = ea;
         data_in.man_big   = ma;
         data_in.man_small = mb;
         data_in.shift     = ea - eb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      data_ff <= data_in;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
endmodule
`default_nettype wire

[sv/fat_addsub.sv]
// ---------------------------------------------------------------------------
// fat_addsub: alignment shift and mantissa add or subtract
// truncating right shift of the smaller mantissa, then magnitude sum
// ---------------------------------------------------------------------------
`default_nettype none
module fat_addsub (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               valid_in,
   input  wire fat_pkg::align_type data_in,
   output logic                    valid_out,
   output fat_pkg::sum_type        data_out
);
   logic             valid_ff;
   fat_pkg::sum_type data_ff, sum_in;
   logic [23:0] small_sh;

   always_comb begin
      small_sh = (data_in.shift < 8'd24) ? (data_in.man_small >> data_in.shift[4:0]) : '0;
      sum_in.sign     = data_in.sign;
      sum_in.pass     = data_in.pass;
      sum_in.exp_big  = data_in.exp_big;
      sum_in.pass_man = data_in.man_big;
      if (!data_in.sub)
         sum_in.man_sum = {1'b0, data_in.man_big} + {1'b0, small_sh};
      else if (data_in.man_big > small_sh)
         sum_in.man_sum = {1'b0, data_in.man_big - small_sh};
      else
         sum_in.man_sum = {1'b0, small_sh - data_in.man_big};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      data_ff <= sum_in;
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;
endmodule
`default_nettype wire

[sv/fat_norm.sv]
// ---------------------------------------------------------------------------
// fat_norm: leading-one search and normalisation
// carry bump, zero result, left shift with exponent underflow to zero
// ---------------------------------------------------------------------------
`default_nettype none
module fat_norm (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             valid_in,
   input  wire fat_pkg::sum_type data_in,
   output logic                  valid_out,
   output logic [31:0]           sum_out
);
   logic        valid_ff;
   logic [31:0] sum_ff, sum_in;
   logic [4:0]  lz;
   logic [4:0]  sh;
   logic [24:0] man_sh;
   logic [8:0]  exp_up;

   always_comb begin
      // upward scan, so the highest set bit is written last
      lz = 5'd25;
      for (int k = 0; k <= 24; k++) begin
         if (data_in.man_sum[k]) lz = 5'(24 - k);
      end
      sh     = lz - 5'd1;
      man_sh = data_in.man_sum << sh;
      exp_up = {1'b0, data_in.exp_big} + 9'd1;
      if (data_in.pass) begin
         sum_in = {data_in.sign, data_in.exp_big, data_in.pass_man[22:0]};
      end else if (lz == 5'd0) begin
         // carry: exponent 255 wraps into the sign bit
         sum_in = {data_in.sign | exp_up[8], exp_up[7:0], data_in.man_sum[23:1]};
      end else if (lz == 5'd25) begin
         sum_in = {data_in.sign, 31'd0};
      end else if ({3'd0, sh} < data_in.exp_big) begin
         sum_in = {data_in.sign, data_in.exp_big - {3'd0, sh}, man_sh[22:0]};
      end else begin
         sum_in = {data_in.sign, 8'd0, man_sh[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      sum_ff <= sum_in;
   end

   assign valid_out = valid_ff;
   assign sum_out   = sum_ff;
endmodule
`default_nettype wire

[sv/float32_add_truncating.sv]
// ---------------------------------------------------------------------------
// float32_add_truncating: truncating single-precision adder
// three-stage pipeline adding two float bit patterns without rounding
// ---------------------------------------------------------------------------
// usage
//   input: drive req_operand_a / req_operand_b and raise start; the item is
//   taken on any edge where start is high and busy is low. busy is always
//   low, so one item enters every cycle.
//   output: rsp_valid is high for exactly one cycle with rsp_sum_bits; the
//   receiver cannot hold results off and needs none.
//   stages: align, add/subtract, normalise, each ended by a register;
//   the result reaches the ports from the normalise register.
//   throughput: one item per cycle, since every stage reloads each cycle
//   and nothing feeds back between items.
//   reset: synchronous, clears all valid bits; items in flight are dropped.
//   inf and nan are added as plain numbers, exponent zero counts as zero.
// ---------------------------------------------------------------------------
`default_nettype none
module float32_add_truncating (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_operand_a,
   input  wire logic [31:0] req_operand_b,
   output logic             rsp_valid,
   output logic [31:0]      rsp_sum_bits
);
   logic               v1, v2;
   fat_pkg::align_type d1;
   fat_pkg::sum_type   d2;

   // pipeline never stalls
   assign busy = 1'b0;

   // stage 1: unpack, sign rule, operand order
   fat_align u_align (
      .clock(clock), .reset(reset), .valid_in(start & ~busy),
      .a_in(req_operand_a), .b_in(req_operand_b),
      .valid_out(v1), .data_out(d1)
   );

   // stage 2: align and add or subtract
   fat_addsub u_addsub (
      .clock(clock), .reset(reset), .valid_in(v1), .data_in(d1),
      .valid_out(v2), .data_out(d2)
   );

   // stage 3: normalise and pack
   fat_norm u_norm (
      .clock(clock), .reset(reset), .valid_in(v2), .data_in(d2),
      .valid_out(rsp_valid), .sum_out(rsp_sum_bits)
   );
endmodule
`default_nettype wire
